@@ src/lsi_pkg.sv @@
// ----------------------------------------------------------------------------
// Line segment intersection package
// Shared types and constants for the segment crossing pipeline.
// ----------------------------------------------------------------------------
package lsi_pkg;

    localparam int TOL_W = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // How a segment pair is resolved.
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_SAME,
        CLS_VH,
        CLS_UH,
        CLS_VV,
        CLS_UV,
        CLS_GEN
    } cls_t;

    typedef struct packed {
        cls_t cls;
        logic sel1;
        logic sel2;
        logic bound_first;
        logic bound_second;
    } lsi_ctrl_t;

endpackage

@@ src/lsi_front.sv @@
// ----------------------------------------------------------------------------
// Line segment intersection front end
// Takes segment pairs, forms differences, classifies each pair and forms the
// products needed by the back end.
// ----------------------------------------------------------------------------
module lsi_front #(
    parameter int W = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [15:0]             tol,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [W-1:0]     ax,
    input  logic signed [W-1:0]     ay,
    input  logic signed [W-1:0]     bx,
    input  logic signed [W-1:0]     by,
    input  logic signed [W-1:0]     cx,
    input  logic signed [W-1:0]     cy,
    input  logic signed [W-1:0]     dx,
    input  logic signed [W-1:0]     dy,
    input  logic                    bound_first,
    input  logic                    bound_second,
    output logic                    push,
    input  logic                    full,
    output lsi_pkg::lsi_ctrl_t      ctrl,
    output logic signed [2*W+2:0]   k_out,
    output logic signed [2*W+2:0]   n_out,
    output logic signed [W:0]       ux_out,
    output logic signed [W:0]       uy_out,
    output logic signed [2*W+1:0]   sp_num,
    output logic signed [W:0]       sp_den,
    output logic signed [W-1:0]     base_x,
    output logic signed [W-1:0]     base_y,
    output logic signed [W-1:0]     lo1,
    output logic signed [W-1:0]     hi1,
    output logic signed [W-1:0]     lo2,
    output logic signed [W-1:0]     hi2
);
    import lsi_pkg::*;

    localparam int D     = W + 1;
    localparam int P     = 2 * D;
    localparam int K     = P + 1;
    localparam int CMP_W = (D > TOL_W) ? D : TOL_W;

    logic adv;
    logic v1_reg;
    logic v2_reg;

    // Stage 1: differences and raw coordinates
    logic signed [D-1:0] ux_next, uy_next, vx_next, vy_next, wx_next, wy_next;
    logic signed [D-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg, dx_reg, dy_reg;
    logic                bf_reg, bs_reg;

    // Stage 2: class and products
    logic [D-1:0]        aux, auy, avx, avy, awx, awy;
    logic [CMP_W-1:0]    tol_c;
    logic                uxs, uys, vxs, vys, wxs, wys;
    cls_t                cls;
    logic signed [D-1:0] m1, m2, sden;
    logic signed [W-1:0] bxs, bys, l1, h1, l2, h2;

    cls_t                cls_reg;
    logic                sel1_reg, sel2_reg, bf2_reg, bs2_reg;
    logic signed [P-1:0] pk1_reg, pk2_reg, pn1_reg, pn2_reg, ps_reg;
    logic signed [D-1:0] sden_reg, ux2_reg, uy2_reg;
    logic signed [W-1:0] bx_sel_reg, by_sel_reg, lo1_reg, hi1_reg, lo2_reg, hi2_reg;

    assign adv      = !v2_reg || !full;
    assign in_ready = adv;
    assign push     = v2_reg && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign ux_next = D'(bx) - D'(ax);
    assign uy_next = D'(by) - D'(ay);
    assign vx_next = D'(dx) - D'(cx);
    assign vy_next = D'(dy) - D'(cy);
    assign wx_next = D'(cx) - D'(ax);
    assign wy_next = D'(cy) - D'(ay);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            wx_reg <= wx_next;
            wy_reg <= wy_next;
            ax_reg <= ax;
            ay_reg <= ay;
            bx_reg <= bx;
            by_reg <= by;
            cx_reg <= cx;
            cy_reg <= cy;
            dx_reg <= dx;
            dy_reg <= dy;
            bf_reg <= bound_first;
            bs_reg <= bound_second;
        end
    end

    // Differences never reach the most negative code, so a plain negate is safe.
    assign aux   = ux_reg[D-1] ? -ux_reg : ux_reg;
    assign auy   = uy_reg[D-1] ? -uy_reg : uy_reg;
    assign avx   = vx_reg[D-1] ? -vx_reg : vx_reg;
    assign avy   = vy_reg[D-1] ? -vy_reg : vy_reg;
    assign awx   = wx_reg[D-1] ? -wx_reg : wx_reg;
    assign awy   = wy_reg[D-1] ? -wy_reg : wy_reg;
    assign tol_c = CMP_W'(tol);
    assign uxs   = CMP_W'(aux) < tol_c;
    assign uys   = CMP_W'(auy) < tol_c;
    assign vxs   = CMP_W'(avx) < tol_c;
    assign vys   = CMP_W'(avy) < tol_c;
    assign wxs   = CMP_W'(awx) < tol_c;
    assign wys   = CMP_W'(awy) < tol_c;

    always_comb
    begin
        cls = CLS_GEN;
        if (vys)
        begin
            if (!uys)
                cls = CLS_VH;
            else if (wys)
                cls = CLS_SAME;
            else
                cls = CLS_NONE;
        end
        else if (uys)
            cls = CLS_UH;
        else if (vxs)
        begin
            if (ux_reg != '0)
                cls = CLS_VV;
            else if (wxs)
                cls = CLS_SAME;
            else
                cls = CLS_NONE;
        end
        else if (uxs)
            cls = CLS_UV;
    end

    always_comb
    begin
        m1   = '0;
        m2   = '0;
        sden = {{W{1'b0}}, 1'b1};
        bxs  = '0;
        bys  = '0;
        case (cls)
            CLS_VH:
            begin
                m1   = ux_reg;
                m2   = wy_reg;
                sden = uy_reg;
                bxs  = ax_reg;
                bys  = cy_reg;
            end
            CLS_UH:
            begin
                m1   = vx_reg;
                m2   = -wy_reg;
                sden = vy_reg;
                bxs  = cx_reg;
                bys  = ay_reg;
            end
            CLS_VV:
            begin
                m1   = uy_reg;
                m2   = wx_reg;
                sden = ux_reg;
                bxs  = cx_reg;
                bys  = ay_reg;
            end
            CLS_UV:
            begin
                m1   = vy_reg;
                m2   = -wx_reg;
                sden = vx_reg;
                bxs  = ax_reg;
                bys  = cy_reg;
            end
            CLS_SAME:
            begin
                bxs = cx_reg;
                bys = cy_reg;
            end
            CLS_GEN:
            begin
                bxs = ax_reg;
                bys = ay_reg;
            end
            default:
            begin
                bxs = '0;
                bys = '0;
            end
        endcase
    end

    // A segment that runs along x is tested on x, otherwise on y.
    assign l1 = uys ? ((ax_reg < bx_reg) ? ax_reg : bx_reg)
                    : ((ay_reg < by_reg) ? ay_reg : by_reg);
    assign h1 = uys ? ((ax_reg < bx_reg) ? bx_reg : ax_reg)
                    : ((ay_reg < by_reg) ? by_reg : ay_reg);
    assign l2 = vys ? ((cx_reg < dx_reg) ? cx_reg : dx_reg)
                    : ((cy_reg < dy_reg) ? cy_reg : dy_reg);
    assign h2 = vys ? ((cx_reg < dx_reg) ? dx_reg : cx_reg)
                    : ((cy_reg < dy_reg) ? dy_reg : cy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg    <= cls;
            sel1_reg   <= uys;
            sel2_reg   <= vys;
            bf2_reg    <= bf_reg;
            bs2_reg    <= bs_reg;
            pk1_reg    <= ux_reg * vy_reg;
            pk2_reg    <= uy_reg * vx_reg;
            pn1_reg    <= wx_reg * vy_reg;
            pn2_reg    <= wy_reg * vx_reg;
            ps_reg     <= m1 * m2;
            sden_reg   <= sden;
            ux2_reg    <= ux_reg;
            uy2_reg    <= uy_reg;
            bx_sel_reg <= bxs;
            by_sel_reg <= bys;
            lo1_reg    <= l1;
            hi1_reg    <= h1;
            lo2_reg    <= l2;
            hi2_reg    <= h2;
        end
    end

    assign ctrl.cls          = cls_reg;
    assign ctrl.sel1         = sel1_reg;
    assign ctrl.sel2         = sel2_reg;
    assign ctrl.bound_first  = bf2_reg;
    assign ctrl.bound_second = bs2_reg;
    assign k_out             = K'(pk1_reg) - K'(pk2_reg);
    assign n_out             = K'(pn1_reg) - K'(pn2_reg);
    assign ux_out            = ux2_reg;
    assign uy_out            = uy2_reg;
    assign sp_num            = ps_reg;
    assign sp_den            = sden_reg;
    assign base_x            = bx_sel_reg;
    assign base_y            = by_sel_reg;
    assign lo1               = lo1_reg;
    assign hi1               = hi1_reg;
    assign lo2               = lo2_reg;
    assign hi2               = hi2_reg;

endmodule

@@ src/lsi_fifo.sv @@
// ----------------------------------------------------------------------------
// Line segment intersection queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lsi_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              not_empty
);
    import lsi_pkg::*;

    logic [DATA_W-1:0]     mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;

    assign full      = count_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign rdata     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ src/lsi_div.sv @@
// ----------------------------------------------------------------------------
// Line segment intersection divider
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// stage in front that flags quotients too large for the coordinate range.
// ----------------------------------------------------------------------------
module lsi_div #(
    parameter int W = 24
) (
    input  logic            clk,
    input  logic            en,
    input  logic [3*W+4:0]  num,
    input  logic [2*W+3:0]  den,
    output logic [W:0]      quo,
    output logic            ovf
);
    import lsi_pkg::*;

    localparam int QB = W + 1;
    localparam int RW = 3 * W + 5;
    localparam int DW = 2 * W + 4;

    logic [RW-1:0] r_reg   [QB+1];
    logic [DW-1:0] d_reg   [QB+1];
    logic [QB-1:0] q_reg   [1:QB+1];
    logic          ovf_reg [1:QB+1];
    logic [RW-1:0] sh      [1:QB+1];
    logic          ge      [1:QB+1];
    logic [QB-1:0] qbit    [2:QB+1];

    for (genvar j = 1; j <= QB + 1; j++)
    begin : g_cmp
        assign sh[j] = RW'(d_reg[j-1]) << (QB + 1 - j);
        assign ge[j] = r_reg[j-1] >= sh[j];
    end

    for (genvar j = 2; j <= QB + 1; j++)
    begin : g_bit
        assign qbit[j] = ge[j] ? (QB'(1) << (QB + 1 - j)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= num;
            d_reg[0]   <= den;
            ovf_reg[1] <= ge[1];
            q_reg[1]   <= '0;
            for (int j = 1; j <= QB; j++)
            begin
                r_reg[j] <= ge[j] ? r_reg[j-1] - sh[j] : r_reg[j-1];
                d_reg[j] <= d_reg[j-1];
            end
            for (int j = 2; j <= QB + 1; j++)
            begin
                ovf_reg[j] <= ovf_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | qbit[j];
            end
        end
    end

    assign quo = q_reg[QB+1];
    assign ovf = ovf_reg[QB+1];

endmodule

@@ src/lsi_back.sv @@
// ----------------------------------------------------------------------------
// Line segment intersection back end
// Builds numerators and denominators, divides, adds the base point,
// saturates and runs the segment range tests.
// ----------------------------------------------------------------------------
module lsi_back #(
    parameter int W = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  lsi_pkg::lsi_ctrl_t     q_ctrl,
    input  logic signed [2*W+2:0]  q_k,
    input  logic signed [2*W+2:0]  q_n,
    input  logic signed [W:0]      q_ux,
    input  logic signed [W:0]      q_uy,
    input  logic signed [2*W+1:0]  q_sp_num,
    input  logic signed [W:0]      q_sp_den,
    input  logic signed [W-1:0]    q_base_x,
    input  logic signed [W-1:0]    q_base_y,
    input  logic [4*W-1:0]         q_ranges,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   lines_cross,
    output logic                   same_line,
    output logic signed [W-1:0]    cross_x,
    output logic signed [W-1:0]    cross_y,
    output logic                   clipped,
    output logic                   in_segments
);
    import lsi_pkg::*;

    localparam int D   = W + 1;
    localparam int P   = 2 * D;
    localparam int K   = P + 1;
    localparam int L   = W + 2;
    localparam int NW  = 3 * W + 4;
    localparam int RW  = NW + 1;
    localparam int DW  = K + 1;
    localparam int QB  = W + 1;
    localparam int S   = W + 3;
    localparam int LAT = QB + 2;
    localparam int SBW = 8 + 6 * W;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    logic adv;
    logic v1_reg, v2_reg, v3_reg;
    logic vd_reg [LAT];
    logic out_valid_reg;

    // Stage 1: queue head
    lsi_ctrl_t           c1_reg;
    logic signed [K-1:0] k1_reg, n1_reg;
    logic signed [D-1:0] ux1_reg, uy1_reg, spd1_reg;
    logic signed [P-1:0] spn1_reg;
    logic signed [W-1:0] bx1_reg, by1_reg;
    logic [4*W-1:0]      rng1_reg;
    logic signed [L:0]   n_lo;
    logic signed [K-L-1:0] n_hi;

    // Stage 2: partial products
    lsi_ctrl_t             c2_reg;
    logic signed [K-1:0]   k2_reg;
    logic signed [D+L:0]   plx_reg, ply_reg;
    logic signed [D+K-L-1:0] phx_reg, phy_reg;
    logic signed [D-1:0]   spd2_reg;
    logic signed [P-1:0]   spn2_reg;
    logic signed [W-1:0]   bx2_reg, by2_reg;
    logic [4*W-1:0]        rng2_reg;
    logic signed [NW-1:0]  numx_g, numy_g, nx, ny;
    logic signed [K-1:0]   dnx, dny;
    logic                  crossed, same;

    // Stage 3: quotient operands
    logic signed [NW-1:0]  nx_reg, ny_reg;
    logic signed [K-1:0]   dnx_reg, dny_reg;
    logic                  crossed3_reg, same3_reg, sel1_3_reg, sel2_3_reg;
    logic                  bf3_reg, bs3_reg;
    logic signed [W-1:0]   bx3_reg, by3_reg;
    logic [4*W-1:0]        rng3_reg;
    logic [NW-1:0]         anx, any_;
    logic [K-1:0]          adx, ady;
    logic [RW-1:0]         div_num [2];
    logic [DW-1:0]         div_den [2];
    logic [SBW-1:0]        side_in;
    logic [SBW-1:0]        side_reg [LAT];

    // Final stage
    logic [QB-1:0]         quo [2];
    logic                  dovf [2];
    logic                  f_crossed, f_same, f_sel1, f_sel2, f_bf, f_bs;
    logic                  f_neg [2];
    logic signed [W-1:0]   f_base [2];
    logic signed [W-1:0]   f_lo1, f_hi1, f_lo2, f_hi2;
    logic signed [W+1:0]   qs [2];
    logic signed [S-1:0]   sum [2];
    logic signed [W-1:0]   sat [2];
    logic                  clip [2];
    logic signed [S-1:0]   t1, t2;
    logic                  ok1, ok2, on1, on2;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LAT; i++)
                vd_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= q_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vd_reg[0]     <= v3_reg;
            for (int i = 1; i < LAT; i++)
                vd_reg[i] <= vd_reg[i-1];
            out_valid_reg <= vd_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= q_ctrl;
            k1_reg   <= q_k;
            n1_reg   <= q_n;
            ux1_reg  <= q_ux;
            uy1_reg  <= q_uy;
            spd1_reg <= q_sp_den;
            spn1_reg <= q_sp_num;
            bx1_reg  <= q_base_x;
            by1_reg  <= q_base_y;
            rng1_reg <= q_ranges;
        end
    end

    // The wide product u * n is split at bit L into two narrower products.
    assign n_lo = {1'b0, n1_reg[L-1:0]};
    assign n_hi = n1_reg[K-1:L];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg   <= c1_reg;
            k2_reg   <= k1_reg;
            plx_reg  <= ux1_reg * n_lo;
            phx_reg  <= ux1_reg * n_hi;
            ply_reg  <= uy1_reg * n_lo;
            phy_reg  <= uy1_reg * n_hi;
            spd2_reg <= spd1_reg;
            spn2_reg <= spn1_reg;
            bx2_reg  <= bx1_reg;
            by2_reg  <= by1_reg;
            rng2_reg <= rng1_reg;
        end
    end

    assign numx_g = (NW'(phx_reg) <<< L) + NW'(plx_reg);
    assign numy_g = (NW'(phy_reg) <<< L) + NW'(ply_reg);

    // A coordinate taken straight from an end point divides zero by one.
    always_comb
    begin
        nx      = '0;
        ny      = '0;
        dnx     = K'(1);
        dny     = K'(1);
        crossed = 1'b0;
        same    = 1'b0;
        case (c2_reg.cls)
            CLS_VH, CLS_UH:
            begin
                nx      = NW'(spn2_reg);
                dnx     = K'(spd2_reg);
                crossed = 1'b1;
            end
            CLS_VV, CLS_UV:
            begin
                ny      = NW'(spn2_reg);
                dny     = K'(spd2_reg);
                crossed = 1'b1;
            end
            CLS_SAME:
            begin
                crossed = 1'b1;
                same    = 1'b1;
            end
            CLS_GEN:
            begin
                nx      = numx_g;
                ny      = numy_g;
                dnx     = k2_reg;
                dny     = k2_reg;
                crossed = k2_reg != '0;
            end
            default:
            begin
                crossed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg       <= nx;
            ny_reg       <= ny;
            dnx_reg      <= dnx;
            dny_reg      <= dny;
            crossed3_reg <= crossed;
            same3_reg    <= same;
            sel1_3_reg   <= c2_reg.sel1;
            sel2_3_reg   <= c2_reg.sel2;
            bf3_reg      <= c2_reg.bound_first;
            bs3_reg      <= c2_reg.bound_second;
            bx3_reg      <= bx2_reg;
            by3_reg      <= by2_reg;
            rng3_reg     <= rng2_reg;
        end
    end

    // Round to nearest, ties away from zero: (2|n| + |d|) / (2|d|).
    assign anx  = nx_reg[NW-1] ? -nx_reg : nx_reg;
    assign any_ = ny_reg[NW-1] ? -ny_reg : ny_reg;
    assign adx  = dnx_reg[K-1] ? -dnx_reg : dnx_reg;
    assign ady  = dny_reg[K-1] ? -dny_reg : dny_reg;

    assign div_num[0] = {anx, 1'b0} + RW'(adx);
    assign div_num[1] = {any_, 1'b0} + RW'(ady);
    assign div_den[0] = {adx, 1'b0};
    assign div_den[1] = {ady, 1'b0};

    assign side_in = {crossed3_reg, same3_reg,
                      nx_reg[NW-1] ^ dnx_reg[K-1], ny_reg[NW-1] ^ dny_reg[K-1],
                      sel1_3_reg, sel2_3_reg, bf3_reg, bs3_reg,
                      bx3_reg, by3_reg, rng3_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    for (genvar c = 0; c < 2; c++)
    begin : g_div
        lsi_div #(
            .W (W)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (div_num[c]),
            .den (div_den[c]),
            .quo (quo[c]),
            .ovf (dovf[c])
        );
    end

    assign {f_crossed, f_same, f_neg[0], f_neg[1], f_sel1, f_sel2, f_bf, f_bs,
            f_base[0], f_base[1], f_lo1, f_hi1, f_lo2, f_hi2} = side_reg[LAT-1];

    // An overflowing quotient already lies beyond the range whatever the base.
    for (genvar c = 0; c < 2; c++)
    begin : g_fin
        assign qs[c]   = f_neg[c] ? -$signed({1'b0, quo[c]}) : $signed({1'b0, quo[c]});
        assign sum[c]  = S'(f_base[c]) + S'(qs[c]);
        assign clip[c] = dovf[c] || (sum[c] > S'(CMAX)) || (sum[c] < S'(CMIN));
        assign sat[c]  = dovf[c] ? (f_neg[c] ? CMIN : CMAX)
                       : (sum[c] > S'(CMAX)) ? CMAX
                       : (sum[c] < S'(CMIN)) ? CMIN
                       : sum[c][W-1:0];
    end

    assign t1  = f_sel1 ? sum[0] : sum[1];
    assign t2  = f_sel2 ? sum[0] : sum[1];
    assign ok1 = f_sel1 ? !dovf[0] : !dovf[1];
    assign ok2 = f_sel2 ? !dovf[0] : !dovf[1];
    assign on1 = f_crossed && ok1 && (t1 >= S'(f_lo1)) && (t1 <= S'(f_hi1));
    assign on2 = f_crossed && ok2 && (t2 >= S'(f_lo2)) && (t2 <= S'(f_hi2));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lines_cross <= f_crossed;
            same_line   <= f_crossed && f_same;
            cross_x     <= f_crossed ? sat[0] : '0;
            cross_y     <= f_crossed ? sat[1] : '0;
            clipped     <= f_crossed && (clip[0] || clip[1]);
            in_segments <= (on2 || !f_bs) && (on1 || !f_bf);
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/line_segment_intersection_top.sv @@
// ----------------------------------------------------------------------------
// Line segment intersection top level
// Crossing point of two 2D segments in signed fixed point, with axis-aligned
// special cases, saturation and segment range tests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                    Contents
//  s_*       in         s_tvalid/s_tready/s_tdata  ax ay bx by cx cy dx dy
//                       s_tuser                    bound_first bound_second
//  m_*       out        m_tvalid/m_tready/m_tdata  cross_x cross_y
//                       m_tuser                    flags of the crossing
//  cfg_*     in         cfg_we/cfg_wdata           tolerance
//
// One request is taken every cycle while s_tready is high; the two divider
// pipelines retire one quotient bit per stage.
// Reset clears all valid flags and the queue and sets the tolerance to 16.
// The front end and the back end stall independently; a four-entry queue
// sits between them; a valid output is held while m_tready is low.
// ----------------------------------------------------------------------------
module line_segment_intersection_top #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [lsi_pkg::TOL_W-1:0]                cfg_wdata,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // ax, ay, bx, by, cx, cy, dx, dy from the lowest bit up
    input  logic [8*COORD_WIDTH-1:0]                 s_tdata,
    // bound_first, bound_second from the lowest bit up
    input  logic [1:0]                               s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // cross_x, cross_y from the lowest bit up, zero padded
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
    // lines_cross, same_line, clipped, in_segments from the lowest bit up
    output logic [3:0]                               m_tuser
);
    import lsi_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int D      = W + 1;
    localparam int P      = 2 * D;
    localparam int K      = P + 1;
    localparam int OUT_W  = ((2 * W + 7) / 8) * 8;
    localparam int ENTRY_W = $bits(lsi_ctrl_t) + 2 * K + 3 * D + P + 6 * W;

    logic [TOL_W-1:0] tol_reg;

    lsi_ctrl_t           f_ctrl, b_ctrl;
    logic signed [K-1:0] f_k, f_n, b_k, b_n;
    logic signed [D-1:0] f_ux, f_uy, f_spd, b_ux, b_uy, b_spd;
    logic signed [P-1:0] f_spn, b_spn;
    logic signed [W-1:0] f_bx, f_by, f_lo1, f_hi1, f_lo2, f_hi2, b_bx, b_by;
    logic [4*W-1:0]      b_rng;
    logic                push, full, pop, not_empty;
    logic [ENTRY_W-1:0]  wdata, rdata;

    logic                lines_cross, same_line, clipped, in_segments;
    logic signed [W-1:0] cross_x, cross_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    lsi_front #(
        .W (W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .tol          (tol_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .ax           (s_tdata[0*W +: W]),
        .ay           (s_tdata[1*W +: W]),
        .bx           (s_tdata[2*W +: W]),
        .by           (s_tdata[3*W +: W]),
        .cx           (s_tdata[4*W +: W]),
        .cy           (s_tdata[5*W +: W]),
        .dx           (s_tdata[6*W +: W]),
        .dy           (s_tdata[7*W +: W]),
        .bound_first  (s_tuser[0]),
        .bound_second (s_tuser[1]),
        .push         (push),
        .full         (full),
        .ctrl         (f_ctrl),
        .k_out        (f_k),
        .n_out        (f_n),
        .ux_out       (f_ux),
        .uy_out       (f_uy),
        .sp_num       (f_spn),
        .sp_den       (f_spd),
        .base_x       (f_bx),
        .base_y       (f_by),
        .lo1          (f_lo1),
        .hi1          (f_hi1),
        .lo2          (f_lo2),
        .hi2          (f_hi2)
    );

    assign wdata = {f_ctrl, f_k, f_n, f_ux, f_uy, f_spn, f_spd, f_bx, f_by,
                    f_lo1, f_hi1, f_lo2, f_hi2};

    lsi_fifo #(
        .DATA_W (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (wdata),
        .full      (full),
        .pop       (pop),
        .rdata     (rdata),
        .not_empty (not_empty)
    );

    assign {b_ctrl, b_k, b_n, b_ux, b_uy, b_spn, b_spd, b_bx, b_by, b_rng} = rdata;

    lsi_back #(
        .W (W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (not_empty),
        .q_pop       (pop),
        .q_ctrl      (b_ctrl),
        .q_k         (b_k),
        .q_n         (b_n),
        .q_ux        (b_ux),
        .q_uy        (b_uy),
        .q_sp_num    (b_spn),
        .q_sp_den    (b_spd),
        .q_base_x    (b_bx),
        .q_base_y    (b_by),
        .q_ranges    (b_rng),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .lines_cross (lines_cross),
        .same_line   (same_line),
        .cross_x     (cross_x),
        .cross_y     (cross_y),
        .clipped     (clipped),
        .in_segments (in_segments)
    );

    assign m_tdata = OUT_W'({cross_y, cross_x});
    assign m_tuser = {in_segments, clipped, same_line, lines_cross};

    a_same_needs_cross: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("same line reported without a crossing");

    a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("coordinates not zero without a crossing");

    a_clip_needs_cross: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[0])
        else $error("clipped flag without a crossing");

endmodule
